[src/rrlt_pkg.sv]
// Shared types and constants for the range route lookup table.
`default_nettype none

package rrlt_pkg;

  // Fixed widths of the stream fields.
  localparam int TYPE_FIELD_W  = 16;
  localparam int ROUTE_FIELD_W = 8;
  localparam int STATUS_W      = 3;

  // Item kinds carried on the input tuser bit.
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIND = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_ORDER   = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_DUP     = 3'd3,
    STAT_OVERLAP = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    status_t                  status;
    logic                     found;
    logic [ROUTE_FIELD_W-1:0] route;
  } result_t;

endpackage

`default_nettype wire

[src/rrlt_mem.sv]
// Single-port-write, registered-read memory holding the stored ranges.
`default_nettype none

module rrlt_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int W     = 40
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [W-1:0]  wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/rrlt_ctrl.sv]
// Sequencer that walks the range memory at most once per item and builds the result.
`default_nettype none

module rrlt_ctrl #(
  parameter int ENTRIES    = 32,
  parameter int TYPE_BITS  = 16,
  parameter int ROUTE_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input side
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_kind,
  input  wire logic [TYPE_BITS-1:0]  in_lo,
  input  wire logic [TYPE_BITS-1:0]  in_hi,
  input  wire logic [ROUTE_BITS-1:0] in_route,
  input  wire logic [ROUTE_BITS-1:0] default_route,
  // Result side
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output rrlt_pkg::result_t          res
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int W  = 2 * TYPE_BITS + ROUTE_BITS;

  rrlt_pkg::state_t  state, state_next;
  rrlt_pkg::status_t pre_status, pre_status_next;
  rrlt_pkg::status_t final_status;

  logic [AW-1:0]         idx;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_m1;
  logic                  rd_vld;
  logic                  kind;
  logic [TYPE_BITS-1:0]  lo, hi;
  logic [ROUTE_BITS-1:0] route_in, route_hit;
  logic                  hit, dup, ovl;

  logic                  accept, finish;
  logic                  rd_en, wr_en;
  logic [W-1:0]          rd_data, wr_data;
  logic [TYPE_BITS-1:0]  ent_first, ent_last;
  logic [ROUTE_BITS-1:0] ent_route;
  logic                  cmp_hit, cmp_dup, cmp_ovl;
  logic [ROUTE_BITS-1:0] route_sel;

  assign accept   = in_valid && in_ready;
  assign finish   = res_valid && res_ready;
  assign count_m1 = count - CW'(1);

  // Early rejects are decided as the item arrives; they skip the walk.
  always_comb begin
    if (in_kind == rrlt_pkg::KIND_ADD && in_lo > in_hi) begin
      pre_status_next = rrlt_pkg::STAT_ORDER;
    end else if (in_kind == rrlt_pkg::KIND_ADD && count == CW'(ENTRIES)) begin
      pre_status_next = rrlt_pkg::STAT_FULL;
    end else begin
      pre_status_next = rrlt_pkg::STAT_OK;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rrlt_pkg::S_IDLE: begin
        if (in_valid) begin
          if (pre_status_next != rrlt_pkg::STAT_OK || count == '0) begin
            state_next = rrlt_pkg::S_FINISH;
          end else begin
            state_next = rrlt_pkg::S_WALK;
          end
        end
      end
      rrlt_pkg::S_WALK: begin
        if (idx == count_m1[AW-1:0]) begin
          state_next = rrlt_pkg::S_DRAIN;
        end
      end
      rrlt_pkg::S_DRAIN: begin
        state_next = rrlt_pkg::S_FINISH;
      end
      rrlt_pkg::S_FINISH: begin
        if (res_ready) begin
          state_next = rrlt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rrlt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    res_valid = 1'b0;
    case (state)
      rrlt_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      rrlt_pkg::S_WALK: begin
        rd_en = 1'b1;
      end
      rrlt_pkg::S_DRAIN: begin
        rd_en = 1'b0;
      end
      rrlt_pkg::S_FINISH: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Compare the entry that came back from memory against the held item.
  assign ent_first = rd_data[TYPE_BITS-1:0];
  assign ent_last  = rd_data[2*TYPE_BITS-1:TYPE_BITS];
  assign ent_route = rd_data[W-1:2*TYPE_BITS];
  assign cmp_hit   = (ent_first <= lo) && (ent_last >= lo);
  assign cmp_dup   = (ent_first == lo) && (ent_last == hi);
  assign cmp_ovl   = (ent_first <= hi) && (ent_last >= lo);

  // A duplicate anywhere in the table outranks an overlap found earlier.
  always_comb begin
    if (pre_status != rrlt_pkg::STAT_OK) begin
      final_status = pre_status;
    end else if (kind == rrlt_pkg::KIND_FIND) begin
      final_status = rrlt_pkg::STAT_OK;
    end else if (dup) begin
      final_status = rrlt_pkg::STAT_DUP;
    end else if (ovl) begin
      final_status = rrlt_pkg::STAT_OVERLAP;
    end else begin
      final_status = rrlt_pkg::STAT_OK;
    end
  end

  always_comb begin
    if (kind == rrlt_pkg::KIND_ADD) begin
      route_sel = '0;
    end else if (hit) begin
      route_sel = route_hit;
    end else begin
      route_sel = default_route;
    end
  end

  assign res.status = final_status;
  assign res.found  = (kind == rrlt_pkg::KIND_FIND) && hit;
  assign res.route  = rrlt_pkg::ROUTE_FIELD_W'(route_sel);

  // Slots fill in order and are never freed, so the next free slot is the count.
  assign wr_en   = finish && kind == rrlt_pkg::KIND_ADD && final_status == rrlt_pkg::STAT_OK;
  assign wr_data = {route_in, hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rrlt_pkg::S_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (wr_en) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind       <= in_kind;
      lo         <= in_lo;
      hi         <= in_hi;
      route_in   <= in_route;
      pre_status <= pre_status_next;
      idx        <= '0;
      hit        <= 1'b0;
      dup        <= 1'b0;
      ovl        <= 1'b0;
      route_hit  <= '0;
    end else begin
      if (rd_en) begin
        idx <= idx + AW'(1);
      end
      if (rd_vld) begin
        if (cmp_hit && !hit) begin
          route_hit <= ent_route;
        end
        hit <= hit || cmp_hit;
        dup <= dup || cmp_dup;
        ovl <= ovl || cmp_ovl;
      end
    end
  end

  rrlt_mem #(
    .DEPTH (ENTRIES),
    .AW    (AW),
    .W     (W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

[src/range_route_lookup_table.sv]
// Top level of the range route lookup table: ports, register and output stage.
//
//   Channel  Direction  Signals                         Transfer when
//   s_*      in         s_tvalid s_tready s_tdata s_tuser  s_tvalid && s_tready
//   m_*      out        m_tvalid m_tready m_tdata        m_tvalid && m_tready
//   cfg_*    in         cfg_wr_en cfg_wr_data            cfg_wr_en
//
// The block takes a new item only when idle, after the last result has moved into the
// output register; rejects on order or a full table and any item on an empty table
// skip the walk. The walk reads one stored range per cycle through the single read
// port of the range memory. Reset clears the table at once (no clearing pass). A
// stalled result sits in the output register while the next item is walked.
`default_nettype none

module range_route_lookup_table #(
  parameter int ENTRIES    = 32,
  parameter int TYPE_BITS  = 16,
  parameter int ROUTE_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,     // type_begin[15:0], type_end[31:16], route_id[39:32]
  input  wire logic        s_tuser,     // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,     // status[2:0], found[3], route_out[11:4], zero[15:12]
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data  // default_route
);

  logic [ROUTE_BITS-1:0] default_route;
  rrlt_pkg::result_t     res, out_q;
  logic                  res_valid, res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_route <= '0;
    end else if (cfg_wr_en) begin
      default_route <= ROUTE_BITS'(cfg_wr_data);
    end
  end

  rrlt_ctrl #(
    .ENTRIES    (ENTRIES),
    .TYPE_BITS  (TYPE_BITS),
    .ROUTE_BITS (ROUTE_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_kind       (s_tuser),
    .in_lo         (TYPE_BITS'(s_tdata[15:0])),
    .in_hi         (TYPE_BITS'(s_tdata[31:16])),
    .in_route      (ROUTE_BITS'(s_tdata[39:32])),
    .default_route (default_route),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // The output register frees up in the same cycle its transfer completes.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_tdata = {4'b0000, out_q.route, out_q.found, out_q.status};

`ifndef SYNTHESIS
  // One item at a time: a transfer in is always followed by a busy cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken on two consecutive cycles");

  // A lookup hit always reports success.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_q.found) |-> (out_q.status == rrlt_pkg::STAT_OK))
    else $error("found set on a result with error status");

  // Rejected adds carry no route.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_q.status != rrlt_pkg::STAT_OK) |-> (out_q.route == '0))
    else $error("route set on a rejected add");

  // A result is only offered after an item was taken.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !$past(res_valid)) |-> !s_tready)
    else $error("result offered while idle");
`endif

endmodule

`default_nettype wire

[test/tb_range_route_lookup_table.sv]
// Self-checking testbench for the range route lookup table: directed table, random traffic.
`default_nettype none

module tb_range_route_lookup_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES         = 32;
  localparam int ITEMS_PER_PHASE = 550;
  localparam int MAX_REPORTS     = 10;
  localparam int TAIL_CYCLES     = ENTRIES + 8;
  localparam int NUM_ROWS        = 22;

  typedef struct packed {
    logic              kind;
    logic [15:0]       lo;
    logic [15:0]       hi;
    logic [7:0]        rid;
    logic              typed;
    rrlt_pkg::result_t want;
  } route_row_t;

  logic        clk;
  logic        rst         = 1'b1;
  logic        s_tvalid    = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata     = '0;
  logic        s_tuser     = 1'b0;
  logic        m_tvalid;
  logic        m_tready    = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  // Shadow copy of the table and of the default route.
  logic        tbl_valid [ENTRIES] = '{default: 1'b0};
  logic [15:0] tbl_first [ENTRIES];
  logic [15:0] tbl_last  [ENTRIES];
  logic [7:0]  tbl_route [ENTRIES];
  int          tbl_count  = 0;
  logic [7:0]  miss_route = '0;

  rrlt_pkg::result_t route_results_due [$];
  int          mismatches   = 0;
  int          src_idle_pct = 0;
  int          dst_idle_pct = 0;
  logic        hold_req     = 1'b0;
  int          hold_left    = 0;

  route_row_t  route_rows [NUM_ROWS] = '{
    '{rrlt_pkg::KIND_FIND, 16'h0000, 16'h0000, 8'h00, 1'b1, '{rrlt_pkg::STAT_OK, 1'b0, 8'hA5}},
    '{rrlt_pkg::KIND_FIND, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, '{rrlt_pkg::STAT_OK, 1'b0, 8'hA5}},
    '{rrlt_pkg::KIND_ADD, 16'h0010, 16'h0005, 8'h00, 1'b1, '{rrlt_pkg::STAT_ORDER, 1'b0, 8'h00}},
    '{rrlt_pkg::KIND_ADD, 16'h0000, 16'h0000, 8'hFF, 1'b1, '{rrlt_pkg::STAT_OK, 1'b0, 8'h00}},
    '{rrlt_pkg::KIND_ADD, 16'hFFFF, 16'hFFFF, 8'h01, 1'b1, '{rrlt_pkg::STAT_OK, 1'b0, 8'h00}},
    '{rrlt_pkg::KIND_ADD, 16'h0000, 16'h0000, 8'h22, 1'b1, '{rrlt_pkg::STAT_DUP, 1'b0, 8'h00}},
    '{rrlt_pkg::KIND_ADD, 16'h0100, 16'h01FF, 8'h12, 1'b1, '{rrlt_pkg::STAT_OK, 1'b0, 8'h00}},
    '{rrlt_pkg::KIND_ADD, 16'h0180, 16'h0180, 8'h33, 1'b1,
      '{rrlt_pkg::STAT_OVERLAP, 1'b0, 8'h00}},
    '{rrlt_pkg::KIND_ADD, 16'h0080, 16'h0400, 8'h33, 1'b1,
      '{rrlt_pkg::STAT_OVERLAP, 1'b0, 8'h00}},
    '{rrlt_pkg::KIND_ADD, 16'h01FF, 16'h0300, 8'h33, 1'b1,
      '{rrlt_pkg::STAT_OVERLAP, 1'b0, 8'h00}},
    '{rrlt_pkg::KIND_ADD, 16'h0050, 16'h0100, 8'h33, 1'b1,
      '{rrlt_pkg::STAT_OVERLAP, 1'b0, 8'h00}},
    '{rrlt_pkg::KIND_ADD, 16'h0100, 16'h01FF, 8'h99, 1'b1, '{rrlt_pkg::STAT_DUP, 1'b0, 8'h00}},
    '{rrlt_pkg::KIND_ADD, 16'hFFFF, 16'h0000, 8'h44, 1'b1, '{rrlt_pkg::STAT_ORDER, 1'b0, 8'h00}},
    '{rrlt_pkg::KIND_ADD, 16'h0200, 16'h02FF, 8'h00, 1'b0, '0},
    '{rrlt_pkg::KIND_FIND, 16'h0000, 16'hABCD, 8'h5A, 1'b1, '{rrlt_pkg::STAT_OK, 1'b1, 8'hFF}},
    '{rrlt_pkg::KIND_FIND, 16'hFFFF, 16'h0000, 8'h00, 1'b1, '{rrlt_pkg::STAT_OK, 1'b1, 8'h01}},
    '{rrlt_pkg::KIND_FIND, 16'h01FF, 16'h0000, 8'h00, 1'b0, '0},
    '{rrlt_pkg::KIND_FIND, 16'h0200, 16'h0000, 8'h00, 1'b0, '0},
    '{rrlt_pkg::KIND_FIND, 16'h0300, 16'h0000, 8'h00, 1'b1, '{rrlt_pkg::STAT_OK, 1'b0, 8'hA5}},
    '{rrlt_pkg::KIND_FIND, 16'h00FF, 16'h0000, 8'h00, 1'b1, '{rrlt_pkg::STAT_OK, 1'b0, 8'hA5}},
    '{rrlt_pkg::KIND_ADD, 16'h0001, 16'h00FF, 8'h7E, 1'b0, '0},
    '{rrlt_pkg::KIND_FIND, 16'h0001, 16'h0000, 8'h00, 1'b0, '0}
  };

  range_route_lookup_table #(
    .ENTRIES    (ENTRIES),
    .TYPE_BITS  (16),
    .ROUTE_BITS (8)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Works out the result of one item and applies any accepted add to the shadow table.
  function automatic rrlt_pkg::result_t predict_route_result(input logic kind,
                                                             input logic [15:0] lo,
                                                             input logic [15:0] hi,
                                                             input logic [7:0] rid);
    rrlt_pkg::result_t res;
    int      i;
    int      slot;
    res.status = rrlt_pkg::STAT_OK;
    res.found  = 1'b0;
    res.route  = '0;
    slot       = -1;
    if (kind == rrlt_pkg::KIND_FIND) begin
      res.route = miss_route;
      for (i = 0; i < ENTRIES; i++) begin
        if (!res.found && tbl_valid[i] && tbl_first[i] <= lo && tbl_last[i] >= lo) begin
          res.found = 1'b1;
          res.route = tbl_route[i];
        end
      end
    end else if (lo > hi) begin
      res.status = rrlt_pkg::STAT_ORDER;
    end else if (tbl_count >= ENTRIES) begin
      res.status = rrlt_pkg::STAT_FULL;
    end else begin
      for (i = 0; i < ENTRIES; i++) begin
        if (tbl_valid[i] && tbl_first[i] == lo && tbl_last[i] == hi) begin
          res.status = rrlt_pkg::STAT_DUP;
        end
      end
      // Full interval test, so a new range that encloses a stored one is caught too.
      for (i = 0; i < ENTRIES && res.status == rrlt_pkg::STAT_OK; i++) begin
        if (!tbl_valid[i]) begin
          if (slot < 0) slot = i;
        end else if (tbl_first[i] <= hi && tbl_last[i] >= lo) begin
          res.status = rrlt_pkg::STAT_OVERLAP;
        end
      end
      if (res.status == rrlt_pkg::STAT_OK) begin
        tbl_valid[slot] = 1'b1;
        tbl_first[slot] = lo;
        tbl_last[slot]  = hi;
        tbl_route[slot] = rid;
        tbl_count++;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input rrlt_pkg::result_t want,
                                 input logic [15:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: want status %0d found %0d route %0d, got %0d %0d %0d",
               $time, what, want.status, want.found, want.route, got[2:0], got[3], got[11:4]);
    end
  endtask

  always @(posedge clk) begin
    rrlt_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (route_results_due.size() == 0) begin
        report_mismatch("unexpected result", '0, m_tdata);
      end else begin
        want = route_results_due.pop_front();
        if (rrlt_pkg::status_t'(m_tdata[2:0]) !== want.status || m_tdata[3] !== want.found ||
            m_tdata[11:4] !== want.route) begin
          report_mismatch("result mismatch", want, m_tdata);
        end
      end
    end
  end

  // Receiver side; a requested hold-off is counted down here.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  // Offers one item, waits for its transfer and records what should come back.
  task automatic send_item(input logic kind, input logic [15:0] lo, input logic [15:0] hi,
                           input logic [7:0] rid, input logic typed,
                           input rrlt_pkg::result_t typed_res);
    rrlt_pkg::result_t pred;
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {rid, hi, lo};
    do @(posedge clk); while (!s_tready);
    pred = predict_route_result(kind, lo, hi, rid);
    route_results_due.push_back(typed ? typed_res : pred);
  endtask

  // Mostly lookups and adds aimed at stored ranges, with few fresh ranges so that
  // the table fills slowly and the duplicate and overlap paths see a busy table.
  task automatic send_random_item();
    logic        kind;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [7:0]  rid;
    int          r;
    int          i;
    int          k;
    int          p;
    int          d;
    int          off;
    rid = 8'($urandom_range(255));
    hi  = 16'($urandom_range(16'hFFFF));
    i   = -1;
    p   = $urandom_range(ENTRIES - 1);
    for (k = 0; k < ENTRIES; k++) begin
      if (i < 0 && tbl_valid[(p + k) % ENTRIES]) i = (p + k) % ENTRIES;
    end
    r = $urandom_range(99);
    if (r < 50) begin
      kind = rrlt_pkg::KIND_FIND;
      r    = $urandom_range(99);
      if (i < 0 || r < 30) begin
        lo = 16'($urandom_range(16'hFFFF));
      end else if (r < 70) begin
        lo = 16'($urandom_range(tbl_last[i], tbl_first[i]));
      end else begin
        case (r % 4)
          0:       lo = tbl_first[i];
          1:       lo = tbl_last[i];
          2:       lo = tbl_first[i] - 16'd1;
          default: lo = tbl_last[i] + 16'd1;
        endcase
      end
    end else begin
      kind = rrlt_pkg::KIND_ADD;
      r    = $urandom_range(99);
      off  = $urandom_range(300);
      if (r < 12) begin
        lo = 16'($urandom_range(16'hFFFF, 1));
        hi = 16'($urandom_range(lo - 1));
      end else if (i < 0 || r >= 96) begin
        lo = 16'($urandom_range(16'hFFFF));
        d  = lo + $urandom_range(15);
        hi = (d > 65535) ? 16'hFFFF : d[15:0];
      end else if (r < 32) begin
        lo = tbl_first[i];
        hi = tbl_last[i];
      end else if (r < 93) begin
        p  = $urandom_range(tbl_last[i], tbl_first[i]);
        d  = p - off;
        lo = (d < 0) ? 16'h0000 : d[15:0];
        off = $urandom_range(300);
        d  = p + off;
        hi = (d > 65535) ? 16'hFFFF : d[15:0];
      end else begin
        lo = 16'($urandom_range(16'hFFFF));
        d  = lo + $urandom_range(1023);
        hi = (d > 65535) ? 16'hFFFF : d[15:0];
      end
    end
    send_item(kind, lo, hi, rid, 1'b0, '0);
  endtask

  task automatic write_default_route(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    miss_route  = value;
  endtask

  task automatic wait_drained();
    while (route_results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          n;
    int          phase;
    int          tries;
    logic [15:0] lo;
    logic [15:0] hi;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_default_route(8'hA5);

    for (n = 0; n < NUM_ROWS; n++) begin
      send_item(route_rows[n].kind, route_rows[n].lo, route_rows[n].hi, route_rows[n].rid,
                route_rows[n].typed, route_rows[n].want);
    end
    s_tvalid <= 1'b0;
    wait_drained();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 25;
          dst_idle_pct = 46;
          write_default_route(8'h00);
        end
        1: begin
          src_idle_pct = 46;
          dst_idle_pct = 25;
          write_default_route(8'hFF);
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
          write_default_route(8'($urandom_range(254, 1)));
          // Long receiver stall while items keep coming, so the input backs up.
          hold_req = 1'b1;
        end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) send_random_item();
      s_tvalid <= 1'b0;
      wait_drained();
    end

    // Fill whatever room is left, then try the rejects on a full table.
    src_idle_pct = 10;
    dst_idle_pct = 10;
    write_default_route(8'($urandom_range(255)));
    for (tries = 0; tries < 400 && tbl_count < ENTRIES; tries++) begin
      lo = 16'($urandom_range(16'hFFFF));
      hi = (lo > 16'hFFF0) ? 16'hFFFF : 16'(lo + $urandom_range(15));
      send_item(rrlt_pkg::KIND_ADD, lo, hi, 8'($urandom_range(255)), 1'b0, '0);
    end
    send_item(rrlt_pkg::KIND_ADD, tbl_first[0], tbl_last[0], 8'h11, 1'b0, '0);
    send_item(rrlt_pkg::KIND_ADD, 16'h0002, 16'h0001, 8'h22, 1'b0, '0);
    send_item(rrlt_pkg::KIND_ADD, tbl_first[1], tbl_first[1], 8'h33, 1'b0, '0);
    for (n = 0; n < 20; n++) send_random_item();
    s_tvalid <= 1'b0;
    wait_drained();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
src/rrlt_pkg.sv
src/rrlt_mem.sv
src/rrlt_ctrl.sv
src/range_route_lookup_table.sv
test/tb_range_route_lookup_table.sv
